@@ rtl/core/ple_pkg.sv @@
package ple_pkg;

    localparam int CAPACITY = 64;
    localparam int VALUE_W  = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 7;
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef enum logic [2:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_BACK  = 3'd1,
        CMD_DEL_FRONT = 3'd2,
        CMD_DEL_BACK  = 3'd3,
        CMD_INS_AT    = 3'd4,
        CMD_DEL_AT    = 3'd5,
        CMD_READ_OUT  = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_BADPOS = 2'd1,
        STATUS_EMPTY  = 2'd2,
        STATUS_FULL   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_ROTATE = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic [IDX_W-1:0]   pos;
    } t_cell_ctl;

    function automatic logic [VALUE_W-1:0] to_entry(input logic signed [31:0] v);
        return VALUE_W'(64'(v));
    endfunction

    function automatic logic signed [31:0] to_element(input logic [VALUE_W-1:0] e);
        logic signed [VALUE_W-1:0] s;
        s = e;
        return 32'(64'(s));
    endfunction

endpackage

@@ rtl/core/ple_cell.sv @@
module ple_cell
    import ple_pkg::*;
(
    input  logic                i_clk,
    input  logic [IDX_W-1:0]    i_idx,
    input  t_cell_ctl           i_ctl,
    input  logic [VALUE_W-1:0]  i_value,
    input  logic [VALUE_W-1:0]  i_prev,
    input  logic [VALUE_W-1:0]  i_next,
    input  logic [VALUE_W-1:0]  i_head,
    output logic [VALUE_W-1:0]  o_entry
);

    logic [VALUE_W-1:0] r_entry;
    logic [VALUE_W-1:0] n_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_ctl.op)
            CELL_INSERT: begin
                if (i_idx == i_ctl.pos) begin
                    n_entry = i_value;
                end else if (i_idx > i_ctl.pos) begin
                    n_entry = i_prev;
                end
            end
            CELL_DELETE: begin
                if (i_idx >= i_ctl.pos) begin
                    n_entry = i_next;
                end
            end
            CELL_ROTATE: begin
                if (i_idx < i_ctl.pos) begin
                    n_entry = i_next;
                end else if (i_idx == i_ctl.pos) begin
                    n_entry = i_head;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

@@ rtl/core/ple_chain.sv @@
module ple_chain
    import ple_pkg::*;
(
    input  logic                i_clk,
    input  t_cell_ctl           i_ctl,
    input  logic [VALUE_W-1:0]  i_value,
    output logic [VALUE_W-1:0]  o_head
);

    logic [VALUE_W-1:0] w_entry [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VALUE_W-1:0] w_prev;
        logic [VALUE_W-1:0] w_next;

        if (g == 0) begin : g_first
            assign w_prev = w_entry[g];
        end else begin : g_mid_prev
            assign w_prev = w_entry[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_next = w_entry[g];
        end else begin : g_mid_next
            assign w_next = w_entry[g+1];
        end

        ple_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   (IDX_W'(g)),
            .i_ctl   (i_ctl),
            .i_value (i_value),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .i_head  (w_entry[0]),
            .o_entry (w_entry[g])
        );
    end

    assign o_head = w_entry[0];

endmodule

@@ rtl/core/positional_list_engine.sv @@
// Positional list engine: an ordered list of up to CAPACITY signed values.
// Input channel (i_valid / o_stall) takes one command transaction: i_cmd,
// i_value and i_position. Output channel (o_valid / i_stall) returns result
// transactions: o_status, o_count, o_element, o_element_valid and o_last.
// Insert and delete commands change the list in the accept cycle; they and
// unused commands each give one registered result. Such commands can be
// accepted every cycle while the receiver keeps taking results.
// Read out of a non-empty list streams one entry per cycle while the receiver
// keeps taking results, in order, with o_last on the final one. The list
// rotates through its first cell: each entry is taken from the head and
// registered in turn, and no command is accepted until the final entry has
// been registered. Read out of an empty list gives one result with status
// empty.
// Every entry at or past the position shifts to its neighbor cell at once, so
// positional inserts and deletes take no longer than those at the ends.
// Reset (i_rst_n low, synchronous) empties the list and drops any pending
// result. While i_stall is high with a result pending, the result holds on
// the outputs; the block stalls new commands and pauses a read out in progress.
module positional_list_engine
    import ple_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [2:0]          i_cmd,
    input  logic signed [31:0]  i_value,
    input  logic [POS_W-1:0]    i_position,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [1:0]          o_status,
    output logic [6:0]          o_count,
    output logic signed [31:0]  o_element,
    output logic                o_element_valid,
    output logic                o_last
);

    typedef enum logic {
        S_IDLE,
        S_STREAM
    } t_state;

    t_state              r_state,  n_state;
    logic [CNT_W-1:0]    r_count,  n_count;
    logic [CNT_W-1:0]    r_left,   n_left;
    logic                r_out_valid, n_out_valid;
    t_status             r_status, n_status;
    logic signed [31:0]  r_element, n_element;
    logic                r_element_valid, n_element_valid;
    logic                r_last, n_last;

    t_cell_ctl           w_ctl;
    logic [VALUE_W-1:0]  w_head;
    logic                w_take_out;
    logic                w_full;
    logic                w_empty;
    logic [CMP_W-1:0]    w_cnt_x;
    logic [CMP_W-1:0]    w_pos_x;
    logic [IDX_W-1:0]    w_pos_idx;

    assign w_take_out = !r_out_valid || !i_stall;
    assign o_stall    = (r_state != S_IDLE) || !w_take_out;
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_empty    = (r_count == '0);
    assign w_cnt_x    = CMP_W'(r_count);
    assign w_pos_x    = CMP_W'(i_position);
    assign w_pos_idx  = IDX_W'(w_pos_x - CMP_W'(1));

    always_comb begin
        n_state         = r_state;
        n_count         = r_count;
        n_left          = r_left;
        n_out_valid     = r_out_valid && i_stall;
        n_status        = r_status;
        n_element       = r_element;
        n_element_valid = r_element_valid;
        n_last          = r_last;
        w_ctl.op        = CELL_HOLD;
        w_ctl.pos       = '0;

        case (r_state)
            S_IDLE: begin
                if (i_valid && w_take_out) begin
                    n_out_valid     = 1'b1;
                    n_status        = STATUS_OK;
                    n_element       = '0;
                    n_element_valid = 1'b0;
                    n_last          = 1'b1;
                    case (t_cmd'(i_cmd))
                        CMD_INS_FRONT, CMD_INS_BACK: begin
                            if (w_full) begin
                                n_status = STATUS_FULL;
                            end else begin
                                w_ctl.op  = CELL_INSERT;
                                w_ctl.pos = (t_cmd'(i_cmd) == CMD_INS_FRONT) ?
                                            '0 : IDX_W'(r_count);
                                n_count   = r_count + CNT_W'(1);
                            end
                        end
                        CMD_DEL_FRONT, CMD_DEL_BACK: begin
                            if (w_empty) begin
                                n_status = STATUS_EMPTY;
                            end else begin
                                w_ctl.op  = CELL_DELETE;
                                w_ctl.pos = (t_cmd'(i_cmd) == CMD_DEL_FRONT) ?
                                            '0 : IDX_W'(r_count - CNT_W'(1));
                                n_count   = r_count - CNT_W'(1);
                            end
                        end
                        CMD_INS_AT: begin
                            if (w_pos_x == '0 || w_pos_x > w_cnt_x + CMP_W'(1)) begin
                                n_status = STATUS_BADPOS;
                            end else if (w_full) begin
                                n_status = STATUS_FULL;
                            end else begin
                                w_ctl.op  = CELL_INSERT;
                                w_ctl.pos = w_pos_idx;
                                n_count   = r_count + CNT_W'(1);
                            end
                        end
                        CMD_DEL_AT: begin
                            if (w_pos_x == '0 || w_pos_x > w_cnt_x) begin
                                n_status = STATUS_BADPOS;
                            end else begin
                                w_ctl.op  = CELL_DELETE;
                                w_ctl.pos = w_pos_idx;
                                n_count   = r_count - CNT_W'(1);
                            end
                        end
                        CMD_READ_OUT: begin
                            if (w_empty) begin
                                n_status = STATUS_EMPTY;
                            end else begin
                                n_out_valid = r_out_valid && i_stall;
                                n_left      = r_count;
                                n_state     = S_STREAM;
                            end
                        end
                        default: begin
                            n_status = STATUS_OK;
                        end
                    endcase
                end
            end
            S_STREAM: begin
                if (w_take_out) begin
                    n_out_valid     = 1'b1;
                    n_status        = STATUS_OK;
                    n_element       = to_element(w_head);
                    n_element_valid = 1'b1;
                    n_last          = (r_left == CNT_W'(1));
                    w_ctl.op        = CELL_ROTATE;
                    w_ctl.pos       = IDX_W'(r_count - CNT_W'(1));
                    n_left          = r_left - CNT_W'(1);
                    if (r_left == CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
        r_status        <= n_status;
        r_element       <= n_element;
        r_element_valid <= n_element_valid;
        r_last          <= n_last;
    end

    ple_chain u_chain (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_value (to_entry(i_value)),
        .o_head  (w_head)
    );

    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_count         = 7'(r_count);
    assign o_element       = r_element;
    assign o_element_valid = r_element_valid;
    assign o_last          = r_last;

endmodule

@@ bench/positional_list_engine_checker.sv @@
module positional_list_engine_checker
    import ple_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [2:0]         i_cmd,
    input  logic signed [31:0] i_value,
    input  logic [POS_W-1:0]   i_position,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [1:0]         i_status,
    input  logic [6:0]         i_count,
    input  logic signed [31:0] i_element,
    input  logic               i_element_valid,
    input  logic               i_last,
    output int                 o_fail_count,
    output int                 o_outstanding,
    output int                 o_list_len
);

    typedef struct {
        logic [1:0]         status;
        logic [6:0]         count;
        logic signed [31:0] element;
        logic               element_valid;
        logic               last;
    } t_list_result;

    logic [VALUE_W-1:0] list_vals[$];
    t_list_result       result_fifo[$];
    int                 mismatches = 0;
    int                 waiting = 0;
    int                 len_now = 0;

    assign o_fail_count  = mismatches;
    assign o_outstanding = waiting;
    assign o_list_len    = len_now;

    function automatic void queue_result(t_status st, logic signed [31:0] el, logic ev,
                                         logic lst);
        t_list_result r;
        r.status        = st;
        r.count         = 7'(list_vals.size());
        r.element       = el;
        r.element_valid = ev;
        r.last          = lst;
        result_fifo.push_back(r);
    endfunction

    function automatic void apply_list_cmd(logic [2:0] cmd, logic signed [31:0] value,
                                           logic [POS_W-1:0] pos);
        int                        n;
        int                        slot;
        t_status                   st;
        logic signed [63:0]        wide;
        logic signed [VALUE_W-1:0] stored;
        logic signed [31:0]        el;
        n    = list_vals.size();
        slot = -1;
        st   = STATUS_OK;
        wide = value;
        case (cmd)
            CMD_INS_FRONT: slot = 0;
            CMD_INS_BACK:  slot = n;
            CMD_INS_AT: begin
                if (pos < 1 || pos > n + 1) st = STATUS_BADPOS;
                else slot = pos - 1;
            end
            CMD_DEL_FRONT: begin
                if (n == 0) st = STATUS_EMPTY;
                else void'(list_vals.pop_front());
            end
            CMD_DEL_BACK: begin
                if (n == 0) st = STATUS_EMPTY;
                else void'(list_vals.pop_back());
            end
            CMD_DEL_AT: begin
                if (pos < 1 || pos > n) st = STATUS_BADPOS;
                else list_vals.delete(pos - 1);
            end
            CMD_READ_OUT: begin
                if (n == 0) begin
                    queue_result(STATUS_EMPTY, 32'sd0, 1'b0, 1'b1);
                end else begin
                    for (int i = 0; i < n; i++) begin
                        stored = list_vals[i];
                        el     = stored;
                        queue_result(STATUS_OK, el, 1'b1, (i == n - 1));
                    end
                end
                return;
            end
            default: ;
        endcase
        if (slot >= 0) begin
            if (n >= CAPACITY) st = STATUS_FULL;
            else list_vals.insert(slot, wide[VALUE_W-1:0]);
        end
        queue_result(st, 32'sd0, 1'b0, 1'b1);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 'h%0h, actual 'h%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_list_result want;
        if (!i_rst_n) begin
            list_vals.delete();
            result_fifo.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (result_fifo.size() == 0) begin
                    $error("result transaction with no command waiting for it");
                    mismatches++;
                end else begin
                    want = result_fifo.pop_front();
                    check_field("status", 32'(want.status), 32'(i_status));
                    check_field("count", 32'(want.count), 32'(i_count));
                    check_field("element", want.element, i_element);
                    check_field("element_valid", 32'(want.element_valid),
                                32'(i_element_valid));
                    check_field("last", 32'(want.last), 32'(i_last));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                apply_list_cmd(i_cmd, i_value, i_position);
            end
        end
        waiting = result_fifo.size();
        len_now = list_vals.size();
    end

endmodule

@@ bench/positional_list_engine_tb.sv @@
module positional_list_engine_tb;
    import ple_pkg::*;

    localparam logic [2:0] CMD_UNUSED = 3'd7;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BALANCED
    } t_mix;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [2:0]         i_cmd;
    logic signed [31:0] i_value;
    logic [POS_W-1:0]   i_position;
    logic               o_valid;
    logic               i_stall;
    logic [1:0]         o_status;
    logic [6:0]         o_count;
    logic signed [31:0] o_element;
    logic               o_element_valid;
    logic               o_last;

    int fail_count;
    int outstanding;
    int list_len;
    bit idle_en = 1'b1;
    bit hold_receiver = 1'b0;

    positional_list_engine dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_cmd           (i_cmd),
        .i_value         (i_value),
        .i_position      (i_position),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_count         (o_count),
        .o_element       (o_element),
        .o_element_valid (o_element_valid),
        .o_last          (o_last)
    );

    positional_list_engine_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_cmd           (i_cmd),
        .i_value         (i_value),
        .i_position      (i_position),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_status        (o_status),
        .i_count         (o_count),
        .i_element       (o_element),
        .i_element_valid (o_element_valid),
        .i_last          (o_last),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding),
        .o_list_len      (list_len)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #6000000;
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_receiver) begin
                i_stall <= 1'b1;
                repeat (200) @(negedge i_clk);
                hold_receiver = 1'b0;
                i_stall <= 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Offer one command transaction and hold it until accepted.
    task automatic send_cmd(input logic [2:0] c, input logic signed [31:0] v,
                            input logic [POS_W-1:0] p);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_cmd      <= c;
        i_value    <= v;
        i_position <= p;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return 32'sd0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_item(input t_mix mix);
        int               r;
        int               n;
        int               ins_pct;
        int               del_pct;
        logic [2:0]       c;
        logic [POS_W-1:0] p;
        n = list_len;
        case (mix)
            MIX_FILL:  begin ins_pct = 88; del_pct = 4;  end
            MIX_DRAIN: begin ins_pct = 4;  del_pct = 88; end
            default:   begin ins_pct = 42; del_pct = 42; end
        endcase
        r = $urandom_range(0, 99);
        p = POS_W'($urandom_range(0, 127));
        if (r < ins_pct) begin
            case ($urandom_range(0, 2))
                0: c = CMD_INS_FRONT;
                1: c = CMD_INS_BACK;
                default: begin
                    c = CMD_INS_AT;
                    if ($urandom_range(0, 9) != 0) p = POS_W'($urandom_range(1, n + 1));
                end
            endcase
        end else if (r < ins_pct + del_pct) begin
            case ($urandom_range(0, 2))
                0: c = CMD_DEL_FRONT;
                1: c = CMD_DEL_BACK;
                default: begin
                    c = CMD_DEL_AT;
                    if ($urandom_range(0, 9) != 0) p = POS_W'($urandom_range(1, n));
                end
            endcase
        end else if (r < 98) begin
            c = CMD_READ_OUT;
        end else begin
            c = CMD_UNUSED;
        end
        send_cmd(c, pick_value(), p);
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_cmd      = CMD_INS_FRONT;
        i_value    = 32'sd0;
        i_position = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_cmd(CMD_READ_OUT,  32'sd0,         7'd0);
        send_cmd(CMD_DEL_FRONT, 32'sd0,         7'd0);
        send_cmd(CMD_DEL_BACK,  32'sd0,         7'd0);
        send_cmd(CMD_DEL_AT,    32'sd0,         7'd1);
        send_cmd(CMD_INS_AT,    32'sd5,         7'd0);
        send_cmd(CMD_INS_AT,    32'sd6,         7'd2);
        send_cmd(CMD_INS_AT,    32'sh7FFF_FFFF, 7'd1);
        send_cmd(CMD_INS_FRONT, 32'sh8000_0000, 7'd127);
        send_cmd(CMD_INS_BACK,  -32'sd1,        7'd0);
        send_cmd(CMD_INS_BACK,  32'sd0,         7'd0);
        send_cmd(CMD_INS_AT,    32'sd9,         7'd127);
        send_cmd(CMD_INS_AT,    32'sh5555_5555, 7'd5);
        send_cmd(CMD_INS_AT,    32'shAAAA_AAAA, 7'd3);
        send_cmd(CMD_READ_OUT,  32'sd0,         7'd0);
        send_cmd(CMD_DEL_AT,    32'sd0,         7'd0);
        send_cmd(CMD_DEL_AT,    32'sd0,         7'd7);
        send_cmd(CMD_DEL_AT,    32'sd0,         7'd6);
        send_cmd(CMD_DEL_AT,    32'sd0,         7'd2);
        send_cmd(CMD_DEL_FRONT, 32'sd0,         7'd0);
        send_cmd(CMD_DEL_BACK,  32'sd0,         7'd0);
        send_cmd(CMD_UNUSED,    32'sh7FFF_FFFF, 7'd127);
        send_cmd(CMD_READ_OUT,  32'sd0,         7'd0);
        send_cmd(CMD_DEL_AT,    32'sd0,         7'd127);

        for (int i = 0; i < 90; i++) begin
            if (i == 40) hold_receiver = 1'b1;
            random_item(MIX_FILL);
        end
        for (int i = 0; i < 90; i++) random_item(MIX_DRAIN);
        for (int i = 0; i < 40; i++) random_item(MIX_BALANCED);
        idle_en = 1'b0;
        for (int i = 0; i < 40; i++) random_item(MIX_FILL);
        i_valid <= 1'b0;

        wait (outstanding == 0);
        repeat (80) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
